@@ rtl/tccb_pkg.sv @@
// ----------------------------------------------------------------------------
// tccb_pkg
// Shared types and constants for the text console cell buffer.
// ----------------------------------------------------------------------------
package tccb_pkg;

  // Input command kinds (carried on tuser)
  typedef enum logic [1:0] {
    CMD_KEY  = 2'd0,
    CMD_RAW  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Operations handed from the front part to the back part
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_NEWLINE,
    OP_ERASE,
    OP_READ
  } op_t;

  // Character codes
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_PRINT_MIN = 8'd32;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Field widths of the stream payloads
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int LEN_W  = 7;

  // One classified operation in the queue
  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
    logic [LEN_W-1:0]  line_length;
  } op_entry_t;

endpackage

@@ rtl/tccb_front.sv @@
// ----------------------------------------------------------------------------
// tccb_front
// Accepts input beats, tracks the edited line length and turns each beat
// into one grid operation for the back part.
// ----------------------------------------------------------------------------
module tccb_front #(
  parameter int GRID_COLUMNS = 80,
  parameter int GRID_ROWS    = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_command,
  input  logic [7:0]          in_char_code,
  input  logic [4:0]          in_read_row,
  input  logic [6:0]          in_read_col,
  input  logic                init_busy,
  output logic                q_valid,
  input  logic                q_ready,
  output tccb_pkg::op_entry_t q_entry
);
  import tccb_pkg::*;

  localparam int CW = $clog2(GRID_COLUMNS);
  localparam logic [CW-1:0] LEN_MAX = CW'(GRID_COLUMNS - 1);

  logic [CW-1:0] edit_len_r, edit_len_nxt;
  logic [31:0]   len_ext;
  op_t           op;
  logic          rd_in_range;
  logic          accept;

  assign in_tready = q_ready && !init_busy;
  assign q_valid   = in_tvalid && !init_busy;
  assign accept    = in_tvalid && in_tready;

  assign rd_in_range = (32'(in_read_row) < 32'(GRID_ROWS)) &&
                       (32'(in_read_col) < 32'(GRID_COLUMNS));

  // Classify the beat; keystrokes go through line editing here
  always_comb begin
    op           = OP_NOP;
    edit_len_nxt = edit_len_r;
    case (cmd_t'(in_command))
      CMD_KEY: begin
        if (in_char_code == CH_BACKSPACE) begin
          if (edit_len_r != '0) begin
            op           = OP_ERASE;
            edit_len_nxt = edit_len_r - 1'b1;
          end
        end else if (in_char_code == CH_NEWLINE || in_char_code == CH_RETURN) begin
          op           = OP_NEWLINE;
          edit_len_nxt = '0;
        end else if (in_char_code >= CH_PRINT_MIN && edit_len_r < LEN_MAX) begin
          op           = OP_PUT;
          edit_len_nxt = edit_len_r + 1'b1;
        end
      end
      CMD_RAW: begin
        op = (in_char_code == CH_NEWLINE) ? OP_NEWLINE : OP_PUT;
      end
      CMD_READ: begin
        if (rd_in_range) op = OP_READ;
      end
      default: op = OP_NOP;
    endcase
  end

  assign len_ext = 32'(edit_len_nxt);

  always_comb begin
    q_entry.op          = op;
    q_entry.char_code   = in_char_code;
    q_entry.read_row    = in_read_row;
    q_entry.read_col    = in_read_col;
    q_entry.line_length = len_ext[LEN_W-1:0];
  end

  // Edited line length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edit_len_r <= '0;
    end else if (accept) begin
      edit_len_r <= edit_len_nxt;
    end
  end

endmodule

@@ rtl/tccb_queue.sv @@
// ----------------------------------------------------------------------------
// tccb_queue
// Two-entry queue of classified operations between front and back parts.
// ----------------------------------------------------------------------------
module tccb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  tccb_pkg::op_entry_t wr_entry,
  output logic                rd_valid,
  input  logic                rd_ready,
  output tccb_pkg::op_entry_t rd_entry
);
  import tccb_pkg::*;

  op_entry_t  slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_entry = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/tccb_back.sv @@
// ----------------------------------------------------------------------------
// tccb_back
// Executes grid operations: owns the cell memory, the cursor, the scroll
// offset and the result register. Scrolling rotates a row offset and
// sweeps the reused row to spaces.
// ----------------------------------------------------------------------------
module tccb_back #(
  parameter int GRID_COLUMNS = 80,
  parameter int GRID_ROWS    = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  tccb_pkg::op_entry_t q_entry,
  output logic                init_busy,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata
);
  import tccb_pkg::*;

  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLUMNS);
  localparam int CCW   = $clog2(GRID_COLUMNS + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = GRID_ROWS * (2 ** CW);

  localparam logic [RW-1:0]  ROW_LAST = RW'(GRID_ROWS - 1);
  localparam logic [RW:0]    ROWS_EXT = (RW + 1)'(GRID_ROWS);
  localparam logic [CW-1:0]  COL_LAST = CW'(GRID_COLUMNS - 1);
  localparam logic [CCW-1:0] COL_FULL = CCW'(GRID_COLUMNS);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_READ
  } state_t;

  // Physical row of a logical row under the current scroll offset
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                             input logic [RW-1:0] row);
    logic [RW:0] s;
    s = {1'b0, top} + {1'b0, row};
    if (s >= ROWS_EXT) s = s - ROWS_EXT;
    return s[RW-1:0];
  endfunction

  state_t          state_r, state_nxt;
  logic [RW-1:0]   top_r, top_nxt;
  logic [RW-1:0]   crow_r, crow_nxt;
  logic [CCW-1:0]  ccol_r, ccol_nxt;
  logic [RW-1:0]   swp_row_r, swp_row_nxt;
  logic [CW-1:0]   swp_col_r, swp_col_nxt;
  op_t             op_r, op_nxt;
  logic [7:0]      char_r, char_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_cell_r, out_cell_nxt;
  logic [6:0]      out_col_r, out_col_nxt;
  logic [4:0]      out_row_r, out_row_nxt;
  logic [6:0]      out_len_r, out_len_nxt;
  logic            out_scr_r, out_scr_nxt;

  // Memory port signals
  logic [7:0]      mem [DEPTH];
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata_r;

  // Helpers
  logic [RW-1:0]   crow_inc, phys_cur, phys_inc;
  logic [CCW-1:0]  ccol_dec;
  logic [31:0]     ccol_ext, cdec_ext, rrow_ext, rcol_ext;
  logic            slot_free;

  assign crow_inc  = crow_r + 1'b1;
  assign phys_cur  = phys_row(top_r, crow_r);
  assign phys_inc  = phys_row(top_r, crow_inc);
  assign ccol_dec  = ccol_r - 1'b1;
  assign ccol_ext  = 32'(ccol_r);
  assign cdec_ext  = 32'(ccol_dec);
  assign rrow_ext  = 32'(q_entry.read_row);
  assign rcol_ext  = 32'(q_entry.read_col);
  assign slot_free = !out_valid_r || out_tready;

  assign q_ready   = (state_r == S_IDLE) && slot_free;
  assign init_busy = (state_r == S_INIT);

  // Sequencer: next state, cursor, memory access and result load
  always_comb begin
    logic [31:0] col_o, row_o;
    logic        emit;
    logic [7:0]  emit_cell;
    logic        emit_scr;
    logic [LEN_W-1:0] emit_len;

    state_nxt   = state_r;
    top_nxt     = top_r;
    crow_nxt    = crow_r;
    ccol_nxt    = ccol_r;
    swp_row_nxt = swp_row_r;
    swp_col_nxt = swp_col_r;
    op_nxt      = op_r;
    char_nxt    = char_r;
    len_nxt     = len_r;
    we          = 1'b0;
    waddr       = {phys_cur, ccol_ext[CW-1:0]};
    wdata       = CH_SPACE;
    re          = 1'b0;
    raddr       = {phys_row(top_r, rrow_ext[RW-1:0]), rcol_ext[CW-1:0]};
    emit        = 1'b0;
    emit_cell   = 8'd0;
    emit_scr    = 1'b0;
    emit_len    = q_entry.line_length;

    case (state_r)
      // Clear every cell to space after reset
      S_INIT: begin
        we    = 1'b1;
        waddr = {swp_row_r, swp_col_r};
        if (swp_col_r == COL_LAST) begin
          swp_col_nxt = '0;
          if (swp_row_r == ROW_LAST) state_nxt = S_IDLE;
          else swp_row_nxt = swp_row_r + 1'b1;
        end else begin
          swp_col_nxt = swp_col_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (q_valid && slot_free) begin
          op_nxt   = q_entry.op;
          char_nxt = q_entry.char_code;
          len_nxt  = q_entry.line_length;
          case (q_entry.op)
            OP_READ: begin
              re        = 1'b1;
              state_nxt = S_READ;
            end
            OP_ERASE: begin
              emit = 1'b1;
              if (ccol_r != '0) begin
                ccol_nxt = ccol_dec;
                we       = 1'b1;
                waddr    = {phys_cur, cdec_ext[CW-1:0]};
              end
            end
            OP_NEWLINE: begin
              ccol_nxt = '0;
              if (crow_r == ROW_LAST) begin
                swp_col_nxt = '0;
                state_nxt   = S_SWEEP;
              end else begin
                crow_nxt = crow_inc;
                emit     = 1'b1;
              end
            end
            OP_PUT: begin
              if (ccol_r == COL_FULL) begin
                if (crow_r == ROW_LAST) begin
                  swp_col_nxt = '0;
                  state_nxt   = S_SWEEP;
                end else begin
                  crow_nxt = crow_inc;
                  ccol_nxt = CCW'(1);
                  we       = 1'b1;
                  waddr    = {phys_inc, CW'(0)};
                  wdata    = q_entry.char_code;
                  emit     = 1'b1;
                end
              end else begin
                ccol_nxt = ccol_r + 1'b1;
                we       = 1'b1;
                wdata    = q_entry.char_code;
                emit     = 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end

      // Clear the row that becomes the new bottom; a wrapped byte lands
      // in its first column
      S_SWEEP: begin
        we    = 1'b1;
        waddr = {top_r, swp_col_r};
        if (op_r == OP_PUT && swp_col_r == '0) wdata = char_r;
        if (swp_col_r == COL_LAST) begin
          top_nxt   = (top_r == ROW_LAST) ? '0 : top_r + 1'b1;
          ccol_nxt  = (op_r == OP_PUT) ? CCW'(1) : '0;
          emit      = 1'b1;
          emit_scr  = 1'b1;
          emit_len  = len_r;
          state_nxt = S_IDLE;
        end else begin
          swp_col_nxt = swp_col_r + 1'b1;
        end
      end

      S_READ: begin
        emit      = 1'b1;
        emit_cell = rdata_r;
        emit_len  = len_r;
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // Result register
    col_o         = 32'(ccol_nxt);
    row_o         = 32'(crow_nxt);
    out_valid_nxt = out_valid_r && !out_tready;
    out_cell_nxt  = out_cell_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_len_nxt   = out_len_r;
    out_scr_nxt   = out_scr_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_cell_nxt  = emit_cell;
      out_col_nxt   = col_o[6:0];
      out_row_nxt   = row_o[4:0];
      out_len_nxt   = emit_len;
      out_scr_nxt   = emit_scr;
    end
  end

  // State, cursor and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      top_r       <= '0;
      crow_r      <= '0;
      ccol_r      <= '0;
      swp_row_r   <= '0;
      swp_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      crow_r      <= crow_nxt;
      ccol_r      <= ccol_nxt;
      swp_row_r   <= swp_row_nxt;
      swp_col_r   <= swp_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    char_r     <= char_nxt;
    len_r      <= len_nxt;
    out_cell_r <= out_cell_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
    out_len_r  <= out_len_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  // Cell memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_scr_r, out_len_r, out_row_r, out_col_r, out_cell_r};

`ifndef ASSERT_OFF
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    ccol_r <= COL_FULL)
    else $error("cursor column beyond row end");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    crow_r <= ROW_LAST)
    else $error("cursor row beyond grid");

  a_sweep_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWEEP |-> crow_r == ROW_LAST)
    else $error("scroll sweep with cursor off the bottom row");

  a_scroll_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_scr_r |-> $past(state_r) == S_SWEEP)
    else $error("scroll flag raised outside a row sweep");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !q_ready)
    else $error("queue popped while an operation is in flight");
`endif

endmodule

@@ rtl/text_console_cell_buffer_core.sv @@
// Path: each beat is registered in the operation queue, and its result in the
// result register; a cell read also passes the registered memory read.
// Throughput: one beat per cycle for cursor and write operations while results are
// taken; a read holds the back part until its cell is fetched, a scroll while the
// reused row is cleared, and the two-entry queue takes beats until full. Reset:
// synchronous, active low; afterwards a clearing pass fills the grid with spaces before in_tready.
// ----------------------------------------------------------------------------
// text_console_cell_buffer_core
// Character cell console grid with cursor, line editing and scrolling.
// ----------------------------------------------------------------------------
module text_console_cell_buffer_core #(
  parameter int GRID_COLUMNS = 80,
  parameter int GRID_ROWS    = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // cell_char[7:0], cursor_col[14:8],
                                  // cursor_row[19:15], line_length[26:20],
                                  // scrolled[27]
);
  import tccb_pkg::*;

  op_entry_t fq_entry, qb_entry;
  logic      fq_valid, fq_ready, qb_valid, qb_ready;
  logic      init_busy;

  // Classify incoming beats
  tccb_front #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_command   (in_tuser),
    .in_char_code (in_tdata[7:0]),
    .in_read_row  (in_tdata[12:8]),
    .in_read_col  (in_tdata[19:13]),
    .init_busy    (init_busy),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_entry      (fq_entry)
  );

  // Operation queue
  tccb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_entry (fq_entry),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_entry (qb_entry)
  );

  // Grid, cursor and results
  tccb_back #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_entry    (qb_entry),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ sim/text_console_cell_buffer_core_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_cell_buffer_core_tb
// Self-checking bench for the console cell grid. Keystrokes, raw output
// bytes and cell reads stream into the block in random bursts. A local model
// of the grid, the cursor and the edit line predicts every result beat, and
// the result stream is checked field by field under random back-pressure.
// ----------------------------------------------------------------------------
module text_console_cell_buffer_core_tb;
  import tccb_pkg::*;

  localparam int ROWS       = 24;
  localparam int COLS       = 80;
  localparam int N_ITEMS    = 550;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_AT    = 100;
  localparam int HOLD_LEN   = 400;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  ch;
    logic [4:0]  row;
    logic [6:0]  col;
  } console_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [6:0] line_length;
    logic       scrolled;
  } console_view_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // char_code[7:0], read_row[12:8], read_col[19:13]
  logic [1:0]  in_tuser   = '0;   // command[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // cell_char[7:0], cursor_col[14:8],
                                  // cursor_row[19:15], line_length[26:20],
                                  // scrolled[27]

  text_console_cell_buffer_core #(
    .GRID_COLUMNS (COLS),
    .GRID_ROWS    (ROWS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Console model: grid, cursor and edit line
  // --------------------------------------------------------------------------
  logic [7:0]     screen [0:ROWS-1][0:COLS-1];
  int             cur_col;
  int             cur_row;
  int             edit_len;
  bit             scrolled_now;
  console_view_t  expected_status_q[$];

  function automatic void screen_scroll();
    for (int r = 0; r < ROWS - 1; r++)
      for (int c = 0; c < COLS; c++)
        screen[r][c] = screen[r+1][c];
    for (int c = 0; c < COLS; c++)
      screen[ROWS-1][c] = CH_SPACE;
    scrolled_now = 1'b1;
  endfunction

  function automatic void cursor_newline();
    cur_col = 0;
    if (cur_row + 1 >= ROWS) begin
      screen_scroll();
      cur_row = ROWS - 1;
    end else begin
      cur_row++;
    end
  endfunction

  function automatic void console_put(input logic [7:0] ch);
    if (ch == CH_NEWLINE) begin
      cursor_newline();
    end else begin
      // a full row wraps before the byte lands
      if (cur_col >= COLS)
        cursor_newline();
      screen[cur_row][cur_col] = ch;
      cur_col++;
    end
  endfunction

  function automatic void console_key(input logic [7:0] ch);
    if (ch == CH_BACKSPACE) begin
      if (edit_len > 0) begin
        edit_len--;
        if (cur_col > 0) begin
          cur_col--;
          if (cur_col < COLS)
            screen[cur_row][cur_col] = CH_SPACE;
        end
      end
    end else if (ch == CH_NEWLINE || ch == CH_RETURN) begin
      console_put(CH_NEWLINE);
      edit_len = 0;
    end else if (ch >= CH_PRINT_MIN && edit_len < COLS - 1) begin
      edit_len++;
      console_put(ch);
    end
  endfunction

  function automatic console_view_t console_step(input console_item_t it);
    console_view_t v;
    v            = '0;
    scrolled_now = 1'b0;
    case (it.cmd)
      CMD_KEY:  console_key(it.ch);
      CMD_RAW:  console_put(it.ch);
      CMD_READ: begin
        if (it.row < ROWS && it.col < COLS)
          v.cell_char = screen[it.row][it.col];
      end
      default: ;
    endcase
    v.cursor_col  = cur_col[6:0];
    v.cursor_row  = cur_row[4:0];
    v.line_length = edit_len[6:0];
    v.scrolled    = scrolled_now;
    return v;
  endfunction

  initial begin
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        screen[r][c] = CH_SPACE;
    cur_col  = 0;
    cur_row  = 0;
    edit_len = 0;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  console_item_t stim_q[$];

  function automatic void add_item(input cmd_t cmd, input logic [7:0] ch,
                                   input logic [4:0] row, input logic [6:0] col);
    console_item_t it;
    it.cmd = cmd;
    it.ch  = ch;
    it.row = row;
    it.col = col;
    stim_q.push_back(it);
  endfunction

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(CH_PRINT_MIN, 255));
  endfunction

  function automatic void build_stimulus();
    int kind;
    int len;
    // Directed: read extremes, unused command, editing corners
    add_item(CMD_READ, 8'h00, 5'd0, 7'd0);
    add_item(CMD_READ, 8'hFF, 5'd23, 7'd79);
    add_item(CMD_READ, 8'h00, 5'd31, 7'd127);      // off the grid both ways
    add_item(CMD_READ, 8'h00, 5'd24, 7'd5);        // row just past the bottom
    add_item(CMD_READ, 8'h00, 5'd3, 7'd80);        // column just past the edge
    add_item(CMD_NONE, 8'hFF, 5'd31, 7'd127);
    add_item(CMD_KEY, CH_BACKSPACE, 5'd0, 7'd0);   // empty line
    add_item(CMD_KEY, 8'h01, 5'd0, 7'd0);          // control byte, ignored
    add_item(CMD_KEY, 8'hFF, 5'd0, 7'd0);
    add_item(CMD_KEY, 8'h41, 5'd0, 7'd0);
    add_item(CMD_KEY, CH_SPACE, 5'd0, 7'd0);
    add_item(CMD_KEY, CH_BACKSPACE, 5'd0, 7'd0);
    add_item(CMD_RAW, 8'h00, 5'd0, 7'd0);
    add_item(CMD_RAW, CH_BACKSPACE, 5'd0, 7'd0);   // stored, not an erase
    add_item(CMD_RAW, CH_RETURN, 5'd0, 7'd0);      // stored, not a newline
    add_item(CMD_RAW, CH_NEWLINE, 5'd0, 7'd0);
    add_item(CMD_KEY, CH_BACKSPACE, 5'd0, 7'd0);   // line not empty, cursor at col 0
    add_item(CMD_KEY, CH_RETURN, 5'd0, 7'd0);
    add_item(CMD_KEY, CH_NEWLINE, 5'd0, 7'd0);
    add_item(CMD_READ, 8'h00, 5'd0, 7'd0);
    add_item(CMD_READ, 8'h00, 5'd0, 7'd2);
    add_item(CMD_READ, 8'h00, 5'd0, 7'd3);
    add_item(CMD_READ, 8'h00, 5'd0, 7'd4);

    // Random: edited lines, raw output, reads, newline runs and noise
    while (stim_q.size() < N_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 15);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0)
            add_item(CMD_KEY, CH_BACKSPACE, 5'($urandom), 7'($urandom));
          else if ($urandom_range(0, 19) == 0)
            add_item(CMD_KEY, 8'($urandom_range(0, 31)), 5'($urandom), 7'($urandom));
          else
            add_item(CMD_KEY, rand_printable(), 5'($urandom), 7'($urandom));
        end
        add_item(CMD_KEY, $urandom_range(0, 1) ? CH_NEWLINE : CH_RETURN,
                 5'($urandom), 7'($urandom));
      end else if (kind < 60) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0)
            add_item(CMD_RAW, CH_NEWLINE, 5'($urandom), 7'($urandom));
          else
            add_item(CMD_RAW, 8'($urandom_range(0, 255)), 5'($urandom), 7'($urandom));
        end
      end else if (kind < 85) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0)
            add_item(CMD_READ, 8'($urandom), 5'($urandom), 7'($urandom));
          else
            add_item(CMD_READ, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
                     7'($urandom_range(0, COLS - 1)));
        end
      end else if (kind < 92) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          add_item(CMD_RAW, CH_NEWLINE, 5'($urandom), 7'($urandom));
      end else begin
        add_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), 5'($urandom), 7'($urandom));
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: bursts of beats with random gaps
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    console_item_t nxt;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= CMD_KEY;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        nxt = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, nxt.col, nxt.row, nxt.ch};
        in_tuser  <= nxt.cmd;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input beat
  always @(posedge clk) begin
    console_item_t got;
    if (rst_n && in_tvalid && in_tready) begin
      got.cmd = cmd_t'(in_tuser);
      got.ch  = in_tdata[7:0];
      got.row = in_tdata[12:8];
      got.col = in_tdata[19:13];
      expected_status_q.push_back(console_step(got));
    end
  end

  // --------------------------------------------------------------------------
  // Result side: stall pattern plus one long hold-off
  // --------------------------------------------------------------------------
  int results_seen;
  int hold_left;
  bit hold_done;
  int ready_cycle;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      ready_cycle <= 0;
    end else begin
      ready_cycle <= ready_cycle + 1;
      if (hold_left > 0) begin
        out_tready <= 1'b0;
      end else begin
        case ((ready_cycle / 97) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((ready_cycle % 5) != 2);
        endcase
      end
    end
  end

  // Compare each result beat with the oldest prediction
  int mismatches;

  always @(posedge clk) begin
    console_view_t seen;
    console_view_t want;
    if (!rst_n) begin
      results_seen <= 0;
      mismatches   <= 0;
    end else if (out_tvalid && out_tready) begin
      seen.cell_char   = out_tdata[7:0];
      seen.cursor_col  = out_tdata[14:8];
      seen.cursor_row  = out_tdata[19:15];
      seen.line_length = out_tdata[26:20];
      seen.scrolled    = out_tdata[27];
      results_seen <= results_seen + 1;
      if (expected_status_q.size() == 0) begin
        if (mismatches < MAX_REPORT)
          $display("result beat %0d with no prediction pending: %h", results_seen, out_tdata);
        mismatches <= mismatches + 1;
      end else begin
        want = expected_status_q.pop_front();
        if (seen.cell_char != want.cell_char || seen.cursor_col != want.cursor_col ||
            seen.cursor_row != want.cursor_row || seen.line_length != want.line_length ||
            seen.scrolled != want.scrolled) begin
          if (mismatches < MAX_REPORT)
            $display({"result beat %0d: expected char %h col %0d row %0d len %0d scr %0d,",
                      " got char %h col %0d row %0d len %0d scr %0d"}, results_seen,
                     want.cell_char, want.cursor_col, want.cursor_row, want.line_length,
                     want.scrolled, seen.cell_char, seen.cursor_col, seen.cursor_row,
                     seen.line_length, seen.scrolled);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------------
  int cycles;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    @(posedge clk);
    while (!rst_n || stim_q.size() != 0 || in_tvalid || expected_status_q.size() != 0)
      @(posedge clk);
    // let any stray beat surface
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_status_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
